@@ rtl/mfw_pkg.sv @@
`default_nettype none

package mfw_pkg;

    // Window geometry
    localparam int RADIUS    = 1;
    localparam int MAX_WIDTH = 1024;
    localparam int SIDE      = 2 * RADIUS + 1;
    localparam int TAPS      = SIDE * SIDE;
    localparam int MID       = TAPS / 2;

    // Field and counter widths
    localparam int DATA_W  = 16;
    localparam int DIM_W   = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int POS_W   = WIDTH_W + 1;
    localparam int BANK_W  = $clog2(SIDE);
    localparam int LAG_W   = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);
    localparam int RANK_W  = $clog2(TAPS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    // Input beat kinds
    localparam logic KIND_PIXEL = 1'b0;

    // Line bank holding the top window row at frame start: (0 - RADIUS) mod SIDE
    localparam logic [BANK_W-1:0] ROW_BASE_INIT = BANK_W'((SIDE - RADIUS) % SIDE);

    typedef logic signed [DATA_W-1:0] pix_t;
    typedef logic [COL_W-1:0]         col_t;
    typedef logic [BANK_W-1:0]        bank_t;

    // One emitted output position, issued at accept time
    typedef struct packed {
        logic  valid;
        logic  interior;
        logic  last;
        bank_t bank_base;
        col_t  rd_col;
    } emit_t;

    // Line store write of the accepted pixel
    typedef struct packed {
        logic  en;
        bank_t bank;
        col_t  col;
        pix_t  data;
    } wr_t;

    // Control that travels with a window down the pipe
    typedef struct packed {
        logic valid;
        logic interior;
        logic last;
    } stage_t;

    // Final result beat
    typedef struct packed {
        logic valid;
        logic last;
        pix_t median;
    } res_t;

    // Width in use: zero reads as one, clipped to the line store size
    function automatic logic [WIDTH_W-1:0] eff_width(input logic [DIM_W-1:0] v);
        int unsigned x;
        x = 32'(v);
        if (x == 0)
            x = 1;
        else if (x > MAX_WIDTH)
            x = MAX_WIDTH;
        return WIDTH_W'(x);
    endfunction

    function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] v);
        return (v == '0) ? DIM_W'(1) : v;
    endfunction

    // Bank index add, modulo SIDE (both operands below SIDE)
    function automatic bank_t bank_add(input bank_t a, input bank_t b);
        logic [BANK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (BANK_W + 1)'(SIDE))
            s = s - (BANK_W + 1)'(SIDE);
        return s[BANK_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/mfw_ram.sv @@
`default_nettype none

module mfw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/mfw_ctrl.sv @@
`default_nettype none

module mfw_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mfw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mfw_pkg::DIM_W-1:0]      cfg_wdata,
    input  wire logic                           acc,
    input  wire logic                           kind,
    input  wire mfw_pkg::pix_t                  pixel,
    output mfw_pkg::emit_t                      emit,
    output mfw_pkg::wr_t                        wr
);

    logic [mfw_pkg::WIDTH_W-1:0] width_reg;
    logic [mfw_pkg::DIM_W-1:0]   height_reg;
    logic [mfw_pkg::DIM_W-1:0]   in_row_reg;
    mfw_pkg::col_t               in_col_reg;
    mfw_pkg::bank_t              in_bank_reg;
    logic [mfw_pkg::DIM_W-1:0]   out_row_reg;
    mfw_pkg::col_t               out_col_reg;
    mfw_pkg::bank_t              row_base_reg;
    logic [mfw_pkg::LAG_W-1:0]   lag_reg;

    logic                        full;
    logic                        pix_wr;
    logic                        in_col_end;
    logic [mfw_pkg::DIM_W-1:0]   in_row_after;
    logic [mfw_pkg::LAG_W-1:0]   lag_inc;
    logic [mfw_pkg::LAG_W-1:0]   thr;
    logic                        emit_fire;
    logic [mfw_pkg::POS_W-1:0]   col_ahead;
    logic [mfw_pkg::POS_W-1:0]   width_ext;
    logic [mfw_pkg::POS_W-1:0]   rd_col_pos;
    logic                        wrap;
    logic                        out_col_end;
    logic                        out_last;
    logic                        row_inner;
    logic                        col_inner;
    logic                        cfg_hit;

    // Input side: frame fill and line store write
    always_comb
    begin
        full         = in_row_reg >= height_reg;
        pix_wr       = acc && (kind == mfw_pkg::KIND_PIXEL) && !full;
        in_col_end   = (mfw_pkg::WIDTH_W'(in_col_reg) + mfw_pkg::WIDTH_W'(1)) == width_reg;
        in_row_after = in_col_end ? in_row_reg + mfw_pkg::DIM_W'(1) : in_row_reg;
        lag_inc      = lag_reg + mfw_pkg::LAG_W'(1);
        thr          = mfw_pkg::LAG_W'(mfw_pkg::RADIUS) * mfw_pkg::LAG_W'(width_reg)
                     + mfw_pkg::LAG_W'(mfw_pkg::RADIUS);
        emit_fire    = acc && (full || (pix_wr && ((in_row_after >= height_reg) ||
                                                   (lag_inc > thr))));
    end

    // Output side: position, border test and column to fetch
    always_comb
    begin
        width_ext   = mfw_pkg::POS_W'(width_reg);
        col_ahead   = mfw_pkg::POS_W'(out_col_reg) + mfw_pkg::POS_W'(mfw_pkg::RADIUS);
        wrap        = col_ahead >= width_ext;
        rd_col_pos  = wrap ? col_ahead - width_ext : col_ahead;
        out_col_end = (mfw_pkg::WIDTH_W'(out_col_reg) + mfw_pkg::WIDTH_W'(1)) == width_reg;
        out_last    = out_col_end && (out_row_reg == height_reg - mfw_pkg::DIM_W'(1));
        row_inner   = (out_row_reg >= mfw_pkg::DIM_W'(mfw_pkg::RADIUS)) &&
                      (({1'b0, out_row_reg} + (mfw_pkg::DIM_W + 1)'(mfw_pkg::RADIUS)) <
                       {1'b0, height_reg});
        col_inner   = (out_col_reg >= mfw_pkg::COL_W'(mfw_pkg::RADIUS)) && !wrap;

        emit.valid     = emit_fire;
        emit.interior  = row_inner && col_inner;
        emit.last      = out_last;
        emit.bank_base = wrap ? mfw_pkg::bank_add(row_base_reg, mfw_pkg::BANK_W'(1))
                              : row_base_reg;
        emit.rd_col    = mfw_pkg::COL_W'(rd_col_pos);

        wr.en   = pix_wr;
        wr.bank = in_bank_reg;
        wr.col  = in_col_reg;
        wr.data = pixel;
    end

    // Register decode
    always_comb
    begin
        case (cfg_index)
            mfw_pkg::REG_IMAGE_WIDTH:  cfg_hit = cfg_we;
            mfw_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    // Counters; a register write or the last output restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= mfw_pkg::eff_width(mfw_pkg::WIDTH_RESET);
            height_reg   <= mfw_pkg::eff_height(mfw_pkg::HEIGHT_RESET);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_bank_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            row_base_reg <= mfw_pkg::ROW_BASE_INIT;
            lag_reg      <= '0;
        end
        else if (cfg_hit || (emit_fire && out_last))
        begin
            if (cfg_hit)
            begin
                case (cfg_index)
                    mfw_pkg::REG_IMAGE_WIDTH:  width_reg  <= mfw_pkg::eff_width(cfg_wdata);
                    mfw_pkg::REG_IMAGE_HEIGHT: height_reg <= mfw_pkg::eff_height(cfg_wdata);
                    default: ;
                endcase
            end
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_bank_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            row_base_reg <= mfw_pkg::ROW_BASE_INIT;
            lag_reg      <= '0;
        end
        else
        begin
            if (pix_wr)
            begin
                if (in_col_end)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_after;
                    in_bank_reg <= mfw_pkg::bank_add(in_bank_reg, mfw_pkg::BANK_W'(1));
                end
                else
                begin
                    in_col_reg <= in_col_reg + mfw_pkg::COL_W'(1);
                end
            end
            if (emit_fire)
            begin
                if (out_col_end)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + mfw_pkg::DIM_W'(1);
                    row_base_reg <= mfw_pkg::bank_add(row_base_reg, mfw_pkg::BANK_W'(1));
                end
                else
                begin
                    out_col_reg <= out_col_reg + mfw_pkg::COL_W'(1);
                end
            end
            if (pix_wr && !emit_fire)
            begin
                lag_reg <= lag_inc;
            end
            else if (!pix_wr && emit_fire)
            begin
                lag_reg <= lag_reg - mfw_pkg::LAG_W'(1);
            end
        end
    end

    // Positions stay inside the row, lag never runs past the window reach
    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        mfw_pkg::WIDTH_W'(in_col_reg) < width_reg)
        else $error("input column past row end");

    a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        mfw_pkg::WIDTH_W'(out_col_reg) < width_reg)
        else $error("output column past row end");

    a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lag_reg <= thr)
        else $error("pending pixel count beyond window reach");

endmodule

`default_nettype wire

@@ rtl/mfw_window.sv @@
`default_nettype none

module mfw_window (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire mfw_pkg::emit_t   emit,
    input  wire mfw_pkg::wr_t     wr,
    input  wire mfw_pkg::pix_t    ram_q [mfw_pkg::SIDE],
    output mfw_pkg::pix_t         taps  [mfw_pkg::TAPS],
    output mfw_pkg::stage_t       ctrl
);

    mfw_pkg::emit_t              s1_reg;
    logic [mfw_pkg::SIDE-1:0]    byp_hit_reg;
    mfw_pkg::pix_t               byp_data_reg;
    mfw_pkg::pix_t               win_reg [mfw_pkg::SIDE][mfw_pkg::SIDE];
    mfw_pkg::stage_t             s2_reg;
    mfw_pkg::pix_t               col [mfw_pkg::SIDE];

    // Stage 1: fetch in flight; catch a write to the fetched entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int b = 0; b < mfw_pkg::SIDE; b++)
            begin
                byp_hit_reg[b] <= wr.en && (wr.bank == mfw_pkg::BANK_W'(b)) &&
                                  (wr.col == emit.rd_col);
            end
            byp_data_reg <= wr.data;
        end
    end

    // Reorder banks into window rows, top row first
    always_comb
    begin
        for (int dy = 0; dy < mfw_pkg::SIDE; dy++)
        begin
            col[dy] = byp_hit_reg[mfw_pkg::bank_add(s1_reg.bank_base, mfw_pkg::BANK_W'(dy))]
                    ? byp_data_reg
                    : ram_q[mfw_pkg::bank_add(s1_reg.bank_base, mfw_pkg::BANK_W'(dy))];
        end
    end

    // Window shifts one column per output beat
    always_ff @(posedge clk)
    begin
        if (adv && s1_reg.valid)
        begin
            for (int dy = 0; dy < mfw_pkg::SIDE; dy++)
            begin
                for (int dx = 0; dx < mfw_pkg::SIDE - 1; dx++)
                begin
                    win_reg[dy][dx] <= win_reg[dy][dx+1];
                end
                win_reg[dy][mfw_pkg::SIDE-1] <= col[dy];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg.valid    <= s1_reg.valid;
            s2_reg.interior <= s1_reg.interior;
            s2_reg.last     <= s1_reg.last;
        end
    end

    always_comb
    begin
        for (int dy = 0; dy < mfw_pkg::SIDE; dy++)
        begin
            for (int dx = 0; dx < mfw_pkg::SIDE; dx++)
            begin
                taps[dy*mfw_pkg::SIDE+dx] = win_reg[dy][dx];
            end
        end
        ctrl = s2_reg;
    end

endmodule

`default_nettype wire

@@ rtl/mfw_median.sv @@
`default_nettype none

module mfw_median (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire mfw_pkg::pix_t    taps [mfw_pkg::TAPS],
    input  wire mfw_pkg::stage_t  ctrl,
    output mfw_pkg::res_t         res
);

    mfw_pkg::stage_t             a_reg;
    mfw_pkg::pix_t               vals_a_reg [mfw_pkg::TAPS];
    logic [mfw_pkg::TAPS-1:0]    ahead_a_reg [mfw_pkg::TAPS];
    mfw_pkg::stage_t             b_reg;
    mfw_pkg::pix_t               vals_b_reg [mfw_pkg::TAPS];
    logic [mfw_pkg::TAPS-1:0]    sel_b_reg;

    logic [mfw_pkg::TAPS-1:0]    ahead [mfw_pkg::TAPS];
    logic [mfw_pkg::RANK_W-1:0]  rank [mfw_pkg::TAPS];
    logic [mfw_pkg::TAPS-1:0]    sel;
    mfw_pkg::pix_t               pick;

    // Compare matrix: element j sorts ahead of element i (ties by position)
    always_comb
    begin
        for (int i = 0; i < mfw_pkg::TAPS; i++)
        begin
            for (int j = 0; j < mfw_pkg::TAPS; j++)
            begin
                ahead[i][j] = (j < i) ? (taps[j] <= taps[i]) : (taps[j] < taps[i]);
            end
        end
    end

    // Rank of each element; the middle rank is the median
    always_comb
    begin
        for (int i = 0; i < mfw_pkg::TAPS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < mfw_pkg::TAPS; j++)
            begin
                rank[i] = rank[i] + mfw_pkg::RANK_W'(ahead_a_reg[i][j]);
            end
            sel[i] = rank[i] == mfw_pkg::RANK_W'(mfw_pkg::MID);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (adv)
        begin
            a_reg <= ctrl;
            b_reg <= a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vals_a_reg  <= taps;
            ahead_a_reg <= ahead;
            vals_b_reg  <= vals_a_reg;
            sel_b_reg   <= sel;
        end
    end

    // One-hot select; border pixels give zero
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < mfw_pkg::TAPS; i++)
        begin
            pick = pick | (sel_b_reg[i] ? vals_b_reg[i] : mfw_pkg::pix_t'(0));
        end
        res.valid  = b_reg.valid;
        res.last   = b_reg.last;
        res.median = b_reg.interior ? pick : mfw_pkg::pix_t'(0);
    end

    // Border windows may hold stale or unwritten data, so only interior ones are checked
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        b_reg.valid && b_reg.interior |-> $onehot(sel_b_reg))
        else $error("median select is not one-hot");

    a_pick_known: assert property (@(posedge clk) disable iff (!rst_n)
        b_reg.valid && b_reg.interior |-> !$isunknown(pick))
        else $error("interior median has unknown bits");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        b_reg.valid && !b_reg.interior |-> res.median == '0)
        else $error("border median is not zero");

endmodule

`default_nettype wire

@@ rtl/median_filter_window.sv @@
// Streaming square-window median filter (3x3 at RADIUS 1) over a signed 16-bit image sent
// in raster order, one pixel per clock while in_stall is low. Each result beat is the median
// of the window around one output pixel, zero within RADIUS of an image edge, and results
// follow the pixels by RADIUS rows plus RADIUS pixels; once the whole frame is in, flush
// beats (kind = 1) and pixel beats alike drain what is still pending, and last_of_frame
// marks the final result, after which a new frame starts. A register write restarts the
// frame. Line storage is one RAM bank per window row, MAX_WIDTH deep, each with one write
// and one registered read per cycle; no clearing pass is needed after reset. A result
// reaches out_valid through registers for RAM read, window column shift, compare matrix,
// rank select and output register. in_stall follows out_stall while a result waits.
`default_nettype none

module median_filter_window (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mfw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mfw_pkg::DIM_W-1:0]      cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           kind,
    input  wire logic signed [mfw_pkg::DATA_W-1:0] pixel,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [mfw_pkg::DATA_W-1:0]   median,
    output logic                                last_of_frame
);

    logic             adv;
    logic             acc;
    mfw_pkg::emit_t   emit;
    mfw_pkg::wr_t     wr;
    mfw_pkg::pix_t    ram_q [mfw_pkg::SIDE];
    mfw_pkg::pix_t    taps  [mfw_pkg::TAPS];
    mfw_pkg::stage_t  win_ctrl;
    mfw_pkg::res_t    res;

    logic             out_valid_reg;
    mfw_pkg::pix_t    median_reg;
    logic             last_reg;

    // Whole pipe moves unless a finished beat is held at the output
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    mfw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .acc       (acc),
        .kind      (kind),
        .pixel     (pixel),
        .emit      (emit),
        .wr        (wr)
    );

    // One line bank per window row
    for (genvar b = 0; b < mfw_pkg::SIDE; b++)
    begin : g_bank
        logic [mfw_pkg::DATA_W-1:0] q;

        mfw_ram #(
            .WIDTH (mfw_pkg::DATA_W),
            .DEPTH (mfw_pkg::MAX_WIDTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr.en && (wr.bank == mfw_pkg::BANK_W'(b))),
            .wr_addr (wr.col),
            .wr_data (wr.data),
            .rd_en   (adv),
            .rd_addr (emit.rd_col),
            .rd_data (q)
        );

        assign ram_q[b] = q;
    end

    mfw_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .emit  (emit),
        .wr    (wr),
        .ram_q (ram_q),
        .taps  (taps),
        .ctrl  (win_ctrl)
    );

    mfw_median u_median (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .taps  (taps),
        .ctrl  (win_ctrl),
        .res   (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            median_reg <= res.median;
            last_reg   <= res.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign median        = median_reg;
    assign last_of_frame = last_reg;

endmodule

`default_nettype wire

@@ test/median_window_checker.sv @@
`default_nettype none

// Watches the configuration port and both beat channels of the median filter,
// keeps its own copy of the frame state, predicts every result beat and
// compares it with what the block sends.
module median_window_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mfw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mfw_pkg::DIM_W-1:0]          cfg_wdata,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic                               kind,
    input  wire logic signed [mfw_pkg::DATA_W-1:0]  pixel,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic signed [mfw_pkg::DATA_W-1:0]  median,
    input  wire logic                               last_of_frame,
    output int                                      errors,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [mfw_pkg::DATA_W-1:0] value;
        logic                              last;
    } median_beat_t;

    // Frame geometry as last written
    logic [mfw_pkg::DIM_W-1:0] width_reg;
    logic [mfw_pkg::DIM_W-1:0] height_reg;

    // Raster positions of the next pixel taken in and the next median sent out
    int unsigned in_y;
    int unsigned in_x;
    int unsigned out_y;
    int unsigned out_x;

    logic signed [mfw_pkg::DATA_W-1:0] line_rows [mfw_pkg::SIDE][mfw_pkg::MAX_WIDTH];
    median_beat_t                      medians_due [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic int unsigned cols_in_use();
        int unsigned w;
        w = 32'(width_reg);
        if (w == 0)
            w = 1;
        if (w > mfw_pkg::MAX_WIDTH)
            w = mfw_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned rows_in_use();
        return (height_reg == '0) ? 1 : 32'(height_reg);
    endfunction

    task automatic restart_frame();
        in_y  = 0;
        in_x  = 0;
        out_y = 0;
        out_x = 0;
    endtask

    // Work out the median at the current output position and step past it
    task automatic emit_window_median();
        int unsigned                       w;
        int unsigned                       h;
        int                                dy;
        int                                dx;
        int                                i;
        int                                j;
        int                                below;
        int                                not_above;
        logic signed [mfw_pkg::DATA_W-1:0] taps [mfw_pkg::TAPS];
        median_beat_t                      nxt;
        w = cols_in_use();
        h = rows_in_use();
        nxt.value = '0;
        if (out_y >= mfw_pkg::RADIUS && out_y + mfw_pkg::RADIUS < h &&
            out_x >= mfw_pkg::RADIUS && out_x + mfw_pkg::RADIUS < w)
        begin
            for (dy = 0; dy < mfw_pkg::SIDE; dy++)
                for (dx = 0; dx < mfw_pkg::SIDE; dx++)
                    taps[dy * mfw_pkg::SIDE + dx] =
                        line_rows[(out_y - mfw_pkg::RADIUS + dy) % mfw_pkg::SIDE]
                                 [out_x - mfw_pkg::RADIUS + dx];
            // rank select: at most MID taps below it, more than MID not above it
            for (i = 0; i < mfw_pkg::TAPS; i++)
            begin
                below     = 0;
                not_above = 0;
                for (j = 0; j < mfw_pkg::TAPS; j++)
                begin
                    if (taps[j] < taps[i])
                        below++;
                    if (taps[j] <= taps[i])
                        not_above++;
                end
                if (below <= mfw_pkg::MID && not_above > mfw_pkg::MID)
                    nxt.value = taps[i];
            end
        end
        nxt.last = (out_y * w + out_x + 1 == w * h);
        medians_due.insert(medians_due.size(), nxt);
        if (nxt.last)
            restart_frame();
        else
        begin
            out_x++;
            if (out_x >= w)
            begin
                out_x = 0;
                out_y++;
            end
        end
    endtask

    // One accepted input beat
    task automatic take_beat(input logic k, input logic signed [mfw_pkg::DATA_W-1:0] v);
        int unsigned w;
        int unsigned h;
        int unsigned lin_in;
        int unsigned lin_out;
        w = cols_in_use();
        h = rows_in_use();
        if (in_y >= h)
            emit_window_median();   // frame is in: any beat drains one
        else if (k == mfw_pkg::KIND_PIXEL)
        begin
            line_rows[in_y % mfw_pkg::SIDE][in_x] = v;
            in_x++;
            if (in_x >= w)
            begin
                in_x = 0;
                in_y++;
            end
            lin_in  = in_y * w + in_x;
            lin_out = out_y * w + out_x;
            if (in_y >= h || lin_in > lin_out + mfw_pkg::RADIUS * w + mfw_pkg::RADIUS)
                emit_window_median();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        median_beat_t exp_beat;
        if (!rst_n)
        begin
            width_reg  = mfw_pkg::WIDTH_RESET;
            height_reg = mfw_pkg::HEIGHT_RESET;
            restart_frame();
            medians_due.delete();
            pending <= 0;
        end
        else
        begin
            // result beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (medians_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result beat median=%0d last=%0b with none expected",
                                 $realtime, median, last_of_frame);
                    errors++;
                end
                else
                begin
                    exp_beat = medians_due.pop_front();
                    if (exp_beat.value !== median || exp_beat.last !== last_of_frame)
                    begin
                        if (errors < 10)
                            $display("%0t: median exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, exp_beat.value, median,
                                     exp_beat.last, last_of_frame);
                        errors++;
                    end
                end
            end

            // register write restarts the frame
            if (cfg_we)
            begin
                if (cfg_index == mfw_pkg::REG_IMAGE_WIDTH)
                    width_reg = cfg_wdata;
                else if (cfg_index == mfw_pkg::REG_IMAGE_HEIGHT)
                    height_reg = cfg_wdata;
                restart_frame();
            end

            if (in_valid && !in_stall)
                take_beat(kind, pixel);

            pending <= medians_due.size();
        end
    end

endmodule

`default_nettype wire

@@ test/median_filter_window_tb.sv @@
`default_nettype none

module median_filter_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_FLUSH   = ~mfw_pkg::KIND_PIXEL;
    localparam int   CYCLE_LIMIT  = 1000000;
    localparam int   RANDOM_BEATS = 200;
    localparam int   HEIGHT_CAP   = 2047;
    localparam int   WIDE_EXTRA   = 8;

    // which registers a resize writes
    localparam int SET_BOTH   = 0;
    localparam int SET_WIDTH  = 1;
    localparam int SET_HEIGHT = 2;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [mfw_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [mfw_pkg::DIM_W-1:0]         cfg_wdata = '0;
    logic                              in_valid  = 1'b0;
    logic                              kind      = mfw_pkg::KIND_PIXEL;
    logic signed [mfw_pkg::DATA_W-1:0] pixel     = '0;
    logic                              out_stall = 1'b0;
    wire logic                         in_stall;
    wire logic                         out_valid;
    wire logic signed [mfw_pkg::DATA_W-1:0] median;
    wire logic                         last_of_frame;

    int fail_count;
    int results_due;

    logic        calm       = 1'b0;
    logic        quiet      = 1'b0;
    int          stall_left = 0;
    int unsigned cyc        = 0;
    int          beats_done = 0;
    int          pix_style  = 0;

    logic [mfw_pkg::DIM_W-1:0] width_now  = mfw_pkg::WIDTH_RESET;
    logic [mfw_pkg::DIM_W-1:0] height_now = mfw_pkg::HEIGHT_RESET;

    logic signed [mfw_pkg::DATA_W-1:0] corner_px [9] = '{
        16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
        16'h8000, 16'h7fff, 16'h0005, 16'h0005
    };

    median_filter_window u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median        (median),
        .last_of_frame (last_of_frame)
    );

    median_window_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median        (median),
        .last_of_frame (last_of_frame),
        .errors        (fail_count),
        .pending       (results_due)
    );

    always #5 clk = ~clk;

    // Receiver stalls in bursts; stretches without idling come and go
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 300 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
        if (!rst_n || calm)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("median_filter_window_tb NOT OK");
        $finish;
    end

    function automatic int dim_eff(input logic [mfw_pkg::DIM_W-1:0] v, input int cap);
        int x;
        x = int'(v);
        if (x == 0)
            x = 1;
        if (x > cap)
            x = cap;
        return x;
    endfunction

    function automatic logic signed [mfw_pkg::DATA_W-1:0] pick_pixel();
        int sel;
        sel = (pix_style == 3) ? $urandom_range(0, 2) : pix_style;
        case (sel)
            0:       return mfw_pkg::DATA_W'($urandom);
            1:       return mfw_pkg::DATA_W'($urandom_range(0, 6) - 3);   // many ties
            default:
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'hffff;
                    default: return 16'h0000;
                endcase
        endcase
    endfunction

    // Send one beat, with an optional idle burst before it
    task automatic push_beat(input logic k, input logic signed [mfw_pkg::DATA_W-1:0] v);
        if (!calm && !quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        pixel    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold the sender until every predicted result has come out
    task automatic await_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mfw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mfw_pkg::DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [mfw_pkg::DIM_W-1:0] w_raw,
                             input logic [mfw_pkg::DIM_W-1:0] h_raw,
                             input int which);
        await_drain();
        if (which != SET_HEIGHT)
        begin
            write_reg(mfw_pkg::REG_IMAGE_WIDTH, w_raw);
            width_now = w_raw;
        end
        if (which != SET_WIDTH)
        begin
            write_reg(mfw_pkg::REG_IMAGE_HEIGHT, h_raw);
            height_now = h_raw;
        end
        cfg_we <= 1'b0;
    endtask

    // One frame of pixels, then the flush beats that drain it; a cut frame
    // stops partway and must be followed by a register write
    task automatic run_frame(input bit cut);
        int w;
        int h;
        int n;
        int drains;
        int cut_at;
        int i;
        w      = dim_eff(width_now, mfw_pkg::MAX_WIDTH);
        h      = dim_eff(height_now, HEIGHT_CAP);
        n      = w * h;
        drains = (n - 1 < mfw_pkg::RADIUS * w + mfw_pkg::RADIUS) ?
                 n - 1 : mfw_pkg::RADIUS * w + mfw_pkg::RADIUS;
        cut_at = cut ? $urandom_range(0, n - 1) : n;
        for (i = 0; i < cut_at; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                push_beat(KIND_FLUSH, mfw_pkg::DATA_W'($urandom));   // early flush, ignored
            push_beat(mfw_pkg::KIND_PIXEL, pick_pixel());
            beats_done++;
            if ($urandom_range(0, 299) == 0)
                await_drain();
        end
        if (cut_at == n)
        begin
            // a pixel beat after the frame is in acts as a flush
            for (i = 0; i < drains; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_beat(mfw_pkg::KIND_PIXEL, mfw_pkg::DATA_W'($urandom));
                else
                    push_beat(KIND_FLUSH, mfw_pkg::DATA_W'($urandom));
                beats_done++;
            end
            if ($urandom_range(0, 7) == 0)
                push_beat(KIND_FLUSH, mfw_pkg::DATA_W'($urandom));
        end
    endtask

    initial
    begin
        bit                        cut;
        bit                        fresh;
        int                        i;
        int                        r;
        logic [mfw_pkg::DIM_W-1:0] w_raw;
        logic [mfw_pkg::DIM_W-1:0] h_raw;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flush with nothing received, then a partial frame at reset size
        push_beat(KIND_FLUSH, 16'h1234);
        for (i = 0; i < 4; i++)
            push_beat(mfw_pkg::KIND_PIXEL, mfw_pkg::DATA_W'($urandom));

        // 3x3 frame of extreme values with ties, paused mid frame
        set_frame(mfw_pkg::DIM_W'(3), mfw_pkg::DIM_W'(3), SET_BOTH);
        for (i = 0; i < 9; i++)
        begin
            push_beat(mfw_pkg::KIND_PIXEL, corner_px[i]);
            if (i == 4)
                await_drain();
        end
        push_beat(KIND_FLUSH, 16'h0000);
        push_beat(mfw_pkg::KIND_PIXEL, 16'h7fff);
        push_beat(KIND_FLUSH, 16'hffff);
        push_beat(KIND_FLUSH, 16'h8000);
        push_beat(KIND_FLUSH, 16'h5a5a);

        // zero sizes read as one: single pixel frame
        set_frame(mfw_pkg::DIM_W'(0), mfw_pkg::DIM_W'(0), SET_BOTH);
        push_beat(mfw_pkg::KIND_PIXEL, 16'hffff);

        // image smaller than the lag: everything drains
        set_frame(mfw_pkg::DIM_W'(2), mfw_pkg::DIM_W'(1), SET_BOTH);
        push_beat(mfw_pkg::KIND_PIXEL, 16'h8000);
        push_beat(mfw_pkg::KIND_PIXEL, 16'h7fff);
        push_beat(KIND_FLUSH, 16'h0000);

        // random frames, mostly small
        beats_done = 0;
        fresh      = 1'b1;
        while (beats_done < RANDOM_BEATS)
        begin
            if (fresh || $urandom_range(0, 3) != 0)
            begin
                r     = $urandom_range(0, 9);
                w_raw = (r < 8) ? mfw_pkg::DIM_W'($urandom_range(0, 12))
                                : mfw_pkg::DIM_W'($urandom_range(13, 40));
                h_raw = mfw_pkg::DIM_W'($urandom_range(0, 9));
                set_frame(w_raw, h_raw, fresh ? SET_BOTH : $urandom_range(SET_BOTH, SET_HEIGHT));
            end
            cut       = ($urandom_range(0, 9) == 0);
            pix_style = $urandom_range(0, 3);
            run_frame(cut);
            fresh = cut;
        end

        // widest row is clipped to the line store: stop a few pixels into
        // the second row, once the first results are due
        pix_style = 3;
        set_frame(mfw_pkg::DIM_W'(2047), mfw_pkg::DIM_W'(3), SET_BOTH);
        for (i = 0; i < mfw_pkg::MAX_WIDTH + WIDE_EXTRA; i++)
            push_beat(mfw_pkg::KIND_PIXEL, pick_pixel());

        // last stretch with no idling on either side
        calm = 1'b1;
        for (i = 0; i < 4; i++)
        begin
            set_frame(mfw_pkg::DIM_W'($urandom_range(3, 10)),
                      mfw_pkg::DIM_W'($urandom_range(3, 6)), SET_BOTH);
            pix_style = $urandom_range(0, 3);
            run_frame(1'b0);
        end

        await_drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("median_filter_window_tb OK");
        else
            $display("median_filter_window_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/mfw_pkg.sv
rtl/mfw_ram.sv
rtl/mfw_ctrl.sv
rtl/mfw_window.sv
rtl/mfw_median.sv
rtl/median_filter_window.sv
test/median_window_checker.sv
test/median_filter_window_tb.sv
